[hw/rtl/capacitive_pad_baseline_filter_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pad baseline filter
// Shared concurrent-assertion forms, clocked on clk, disabled while arst_n low.
// ----------------------------------------------------------------------------
`ifndef CAPACITIVE_PAD_BASELINE_FILTER_TOP_ASSERT_SVH
`define CAPACITIVE_PAD_BASELINE_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define CPBF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPBF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cpbf_pkg.sv]
// ----------------------------------------------------------------------------
// cpbf_pkg
// Widths, register codes and shared types of the pad baseline filter.
// ----------------------------------------------------------------------------
package cpbf_pkg;

	localparam int READ_W     = 16;
	localparam int AVG_W      = 16;
	localparam int MUL_W      = 10;
	localparam int DIV_W      = 11;
	localparam int NUM_W      = 26;              // reading + avg*mul < 2^26
	localparam int DIV_STEPS  = NUM_W / 2;       // two quotient bits per step
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int TOUCH_W    = 17;
	localparam int CNT_W      = 32;
	localparam int PAD_W      = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 11;

	localparam int PAD_COUNT_DEF = 4;

	localparam logic [AVG_W-1:0]          AVG_MAX     = 16'hFFFF;
	localparam logic signed [TOUCH_W-1:0] TOUCH_FLOOR = -17'sd65000;

	localparam logic [MUL_W-1:0] SHORT_MUL_RST = 10'd3;
	localparam logic [DIV_W-1:0] SHORT_DIV_RST = 11'd4;
	localparam logic [MUL_W-1:0] DEEP_MUL_RST  = 10'd63;
	localparam logic [DIV_W-1:0] DEEP_DIV_RST  = 11'd64;

	localparam logic ACT_SEED   = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_MUL = 8'd0,
		REG_SHORT_DIV = 8'd1,
		REG_DEEP_MUL  = 8'd2,
		REG_DEEP_DIV  = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              start;
		logic [READ_W-1:0] reading;
		logic [AVG_W-1:0]  old;
		logic [MUL_W-1:0]  mul;
		logic [DIV_W-1:0]  div;
	} blend_req_t;

	typedef struct packed {
		logic             done;
		logic [AVG_W-1:0] result;
	} blend_rsp_t;

endpackage

[hw/rtl/cpbf_channels.sv]
// ----------------------------------------------------------------------------
// cpbf channels
// Valid/ready channel interfaces: scan input, result output, register write.
// ----------------------------------------------------------------------------
interface cpbf_in_if;
	import cpbf_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [READ_W-1:0] reading;

	modport source (output valid, output action, output reading, input ready);
	modport sink   (input valid, input action, input reading, output ready);
endinterface

interface cpbf_out_if;
	import cpbf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [PAD_W-1:0]          pad_index;
	logic [AVG_W-1:0]          short_average;
	logic [AVG_W-1:0]          deep_average;
	logic signed [TOUCH_W-1:0] touch_value;
	logic [CNT_W-1:0]          scan_total;

	modport source (output valid, output pad_index, output short_average,
		output deep_average, output touch_value, output scan_total, input ready);
	modport sink   (input valid, input pad_index, input short_average,
		input deep_average, input touch_value, input scan_total, output ready);
endinterface

interface cpbf_cfg_if;
	import cpbf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/cpbf_blend_unit.sv]
// ----------------------------------------------------------------------------
// cpbf_blend_unit
// Shared blend unit: (reading + old*mul) / div, saturated to 16 bits.
// A multiply state, then a radix-4 restoring divide.
// ----------------------------------------------------------------------------
`include "capacitive_pad_baseline_filter_top_assert.svh"

module cpbf_blend_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpbf_pkg::blend_req_t req,
	output cpbf_pkg::blend_rsp_t rsp
);
	import cpbf_pkg::*;

	typedef enum logic [2:0] {
		BU_IDLE = 3'b001,
		BU_MUL  = 3'b010,
		BU_DIV  = 3'b100
	} bu_state_t;

	bu_state_t         state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;

	logic [READ_W-1:0] rd_q;
	logic [AVG_W-1:0]  old_q;
	logic [MUL_W-1:0]  mul_q;
	logic [DIV_W-1:0]  div_q;
	logic [NUM_W-1:0]  acc_q;     // numerator shifts out, quotient shifts in
	logic [DIV_W-1:0]  rem_q;
	logic [AVG_W-1:0]  result_q;

	logic [AVG_W+MUL_W-1:0] prod;
	logic [DIV_W:0]         t1, t2, r1, r2;
	logic                   ge1, ge2;
	logic [NUM_W-1:0]       acc_nxt;
	logic                   last_step;

	assign prod = old_q * mul_q;

	always_comb begin
		t1      = {rem_q, acc_q[NUM_W-1]};
		ge1     = t1 >= {1'b0, div_q};
		r1      = ge1 ? (t1 - {1'b0, div_q}) : t1;
		t2      = {r1[DIV_W-1:0], acc_q[NUM_W-2]};
		ge2     = t2 >= {1'b0, div_q};
		r2      = ge2 ? (t2 - {1'b0, div_q}) : t2;
		acc_nxt = {acc_q[NUM_W-3:0], ge1, ge2};
	end

	assign last_step = (cnt_q == STEP_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BU_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == BU_DIV) && last_step;
			case (state_q)
				BU_IDLE: begin
					if (req.start) begin
						state_q <= BU_MUL;
					end
				end
				BU_MUL: begin
					cnt_q   <= '0;
					state_q <= BU_DIV;
				end
				BU_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= BU_IDLE;
					end
				end
				default: state_q <= BU_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BU_IDLE && req.start) begin
			rd_q  <= req.reading;
			old_q <= req.old;
			mul_q <= req.mul;
			div_q <= (req.div == '0) ? DIV_W'(1) : req.div;  // zero divisor acts as one
		end
		if (state_q == BU_MUL) begin
			acc_q <= NUM_W'(rd_q) + NUM_W'(prod);
			rem_q <= '0;
		end
		if (state_q == BU_DIV) begin
			acc_q <= acc_nxt;
			rem_q <= r2[DIV_W-1:0];
			if (last_step) begin
				result_q <= (|acc_nxt[NUM_W-1:AVG_W]) ? AVG_MAX : acc_nxt[AVG_W-1:0];
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

	`CPBF_ASSERT_IMP(a_start_when_idle, req.start, state_q == BU_IDLE, "blend start while busy")
	`CPBF_ASSERT_IMP(a_div_nonzero, state_q == BU_DIV, div_q != '0, "zero divisor in divide")
	`CPBF_ASSERT_IMP(a_done_after_div, done_q, $past(state_q) == BU_DIV, "done without divide")

endmodule

[hw/rtl/cpbf_pad_store.sv]
// ----------------------------------------------------------------------------
// cpbf_pad_store
// Per-pad fast and slow averages; valid bits make unwritten pads read zero.
// ----------------------------------------------------------------------------
module cpbf_pad_store #(
	parameter int PAD_COUNT = cpbf_pkg::PAD_COUNT_DEF,
	parameter int PTR_W     = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [PTR_W-1:0]           rd_addr,
	output logic [cpbf_pkg::AVG_W-1:0] rd_fast,
	output logic [cpbf_pkg::AVG_W-1:0] rd_slow,
	input  logic                       wr_en,
	input  logic [PTR_W-1:0]           wr_addr,
	input  logic [cpbf_pkg::AVG_W-1:0] wr_fast,
	input  logic [cpbf_pkg::AVG_W-1:0] wr_slow
);
	import cpbf_pkg::*;

	logic [2*AVG_W-1:0]   mem [PAD_COUNT];
	logic [PAD_COUNT-1:0] vld_q;
	logic [2*AVG_W-1:0]   rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_fast, wr_slow};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_fast = rd_vld_q ? rd_q[2*AVG_W-1:AVG_W] : '0;
	assign rd_slow = rd_vld_q ? rd_q[AVG_W-1:0]       : '0;

endmodule

[hw/rtl/capacitive_pad_baseline_filter_top.sv]
// ----------------------------------------------------------------------------
// capacitive_pad_baseline_filter_top
// Dual running-average baseline filter for round-robin capacitive pads.
// ----------------------------------------------------------------------------
// samples : one transaction per completed pad scan (action, reading); pads are
//           served in turn, pad 0 first. action 0 seeds both averages, 1 blends.
// results : one transaction per sample - pad index, new fast and slow averages,
//           touch value (fast - slow, floored at -65000), blend count so far.
// cfg     : register writes (0 short mul, 1 short div, 2 deep mul, 3 deep div),
//           always ready; other indexes dropped. Write only with nothing in flight.
// Sequence: a seed goes from READ straight to write-back; a blend runs the
//  shared blend unit twice, fast then slow (each run: launch, multiply,
//  13 radix-4 divide steps, done). samples.ready is high only while the
//  sequencer is idle, so a new sample waits until the last is written back.
// Reset: all averages read zero, pointer and count clear, gains take defaults.
// Stall: results holds its transaction; the next sample may still be taken but
//  its result waits in write-back, which adds the stall to its latency.
// ----------------------------------------------------------------------------
`include "capacitive_pad_baseline_filter_top_assert.svh"

module capacitive_pad_baseline_filter_top #(
	parameter int PAD_COUNT = cpbf_pkg::PAD_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cpbf_in_if.sink    samples,
	cpbf_out_if.source results,
	cpbf_cfg_if.sink   cfg
);
	import cpbf_pkg::*;

	localparam int PTR_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,   // store data valid; seed, or launch fast blend
		ST_FAST = 5'b00100,   // fast blend running
		ST_SLOW = 5'b01000,   // slow blend running
		ST_WB   = 5'b10000    // write back, load result register
	} seq_state_t;

	// gain registers
	logic [MUL_W-1:0] short_mul_q, deep_mul_q;
	logic [DIV_W-1:0] short_div_q, deep_div_q;

	seq_state_t        state_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  scan_q;
	logic              act_q;
	logic [READ_W-1:0] reading_q;
	logic [AVG_W-1:0]  fast_q, slow_q;

	// result register
	logic                      out_valid_q;
	logic [PAD_W-1:0]          out_pad_q;
	logic [AVG_W-1:0]          out_fast_q, out_slow_q;
	logic signed [TOUCH_W-1:0] out_touch_q;
	logic [CNT_W-1:0]          out_scan_q;

	logic                      in_acc, out_free, wb_fire;
	logic [AVG_W-1:0]          st_fast, st_slow;
	logic [PTR_W-1:0]          ptr_nxt;
	logic [CNT_W-1:0]          scan_nxt;
	logic signed [TOUCH_W-1:0] diff, touch;
	logic [PTR_W+PAD_W-1:0]    ptr_ext;
	blend_req_t                breq;
	blend_rsp_t                brsp;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_mul_q <= SHORT_MUL_RST;
			short_div_q <= SHORT_DIV_RST;
			deep_mul_q  <= DEEP_MUL_RST;
			deep_div_q  <= DEEP_DIV_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_SHORT_MUL: short_mul_q <= cfg.data[MUL_W-1:0];
				REG_SHORT_DIV: short_div_q <= cfg.data[DIV_W-1:0];
				REG_DEEP_MUL:  deep_mul_q  <= cfg.data[MUL_W-1:0];
				REG_DEEP_DIV:  deep_div_q  <= cfg.data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshakes ----------------
	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || results.ready;
	assign wb_fire       = (state_q == ST_WB) && out_free;

	// ---------------- pad store ----------------
	cpbf_pad_store #(
		.PAD_COUNT (PAD_COUNT),
		.PTR_W     (PTR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (ptr_q),
		.rd_fast (st_fast),
		.rd_slow (st_slow),
		.wr_en   (wb_fire),
		.wr_addr (ptr_q),
		.wr_fast (fast_q),
		.wr_slow (slow_q)
	);

	// ---------------- shared blend unit ----------------
	// fast blend launched from READ, slow blend as soon as the fast one ends
	always_comb begin
		breq.start   = ((state_q == ST_READ) && (act_q == ACT_UPDATE)) ||
			((state_q == ST_FAST) && brsp.done);
		breq.reading = reading_q;
		breq.old     = (state_q == ST_FAST) ? st_slow : st_fast;
		breq.mul     = (state_q == ST_FAST) ? deep_mul_q : short_mul_q;
		breq.div     = (state_q == ST_FAST) ? deep_div_q : short_div_q;
	end

	cpbf_blend_unit u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (breq),
		.rsp    (brsp)
	);

	// ---------------- result shaping ----------------
	assign ptr_nxt  = (ptr_q == PTR_W'(PAD_COUNT - 1)) ? '0 : ptr_q + 1'b1;
	assign scan_nxt = (act_q == ACT_UPDATE) ? scan_q + 1'b1 : scan_q;
	assign diff     = $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
	assign touch    = (diff < TOUCH_FLOOR) ? TOUCH_FLOOR : diff;
	assign ptr_ext  = {{PAD_W{1'b0}}, ptr_q};

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.valid && results.ready && !wb_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= (act_q == ACT_UPDATE) ? ST_FAST : ST_WB;
				end
				ST_FAST: begin
					if (brsp.done) begin
						state_q <= ST_SLOW;
					end
				end
				ST_SLOW: begin
					if (brsp.done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (out_free) begin
						ptr_q       <= ptr_nxt;
						scan_q      <= scan_nxt;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q     <= samples.action;
			reading_q <= samples.reading;
		end
		if (state_q == ST_READ && act_q == ACT_SEED) begin
			fast_q <= reading_q;
			slow_q <= reading_q;
		end
		if (state_q == ST_FAST && brsp.done) begin
			fast_q <= brsp.result;
		end
		if (state_q == ST_SLOW && brsp.done) begin
			slow_q <= brsp.result;
		end
		if (wb_fire) begin
			out_pad_q   <= ptr_ext[PAD_W-1:0];
			out_fast_q  <= fast_q;
			out_slow_q  <= slow_q;
			out_touch_q <= touch;
			out_scan_q  <= scan_nxt;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.pad_index     = out_pad_q;
	assign results.short_average = out_fast_q;
	assign results.deep_average  = out_slow_q;
	assign results.touch_value   = out_touch_q;
	assign results.scan_total    = out_scan_q;

	`CPBF_ASSERT_NXT(a_accept_to_read, in_acc, state_q == ST_READ, "accepted sample not read")
	`CPBF_ASSERT_NXT(a_wb_waits, (state_q == ST_WB) && !out_free, (state_q == ST_WB) && $stable(ptr_q), "write-back left while result stalled")
	`CPBF_ASSERT_NXT(a_seed_keeps_count, wb_fire && (act_q == ACT_SEED), scan_q == $past(scan_q), "seed changed the scan count")

endmodule
